### sv/tridiagonal_matrix_vector_multiply_core_assert.svh
// Assertion macros for the tridiagonal matrix-vector core checker.
// Depends on signals named clk and rst_n in the module that expands them.
`ifndef TRIDIAGONAL_MATRIX_VECTOR_MULTIPLY_CORE_ASSERT_SVH
`define TRIDIAGONAL_MATRIX_VECTOR_MULTIPLY_CORE_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define TMVM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check a property on every clock edge, reset included.
`define TMVM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

### sv/tmvm_pkg.sv
// Shared constants and payload types for the tridiagonal matrix-vector core.
// No dependencies; used by the core and its checker.
package tmvm_pkg;

    localparam int MAX_ROWS   = 1024;
    localparam int ADDR_W     = $clog2(MAX_ROWS);
    localparam int LEN_W      = 11;
    localparam int ROW_W      = 10;
    localparam int DATA_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_VECTOR = 1'b1;

    localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic                     mode;
        logic [ROW_W-1:0]         row_index;
        logic signed [DATA_W-1:0] diag_coeff;
        logic signed [DATA_W-1:0] upper_coeff;
        logic signed [DATA_W-1:0] lower_coeff;
        logic signed [DATA_W-1:0] vector_value;
    } req_t;

    typedef struct packed {
        logic [ROW_W-1:0]         out_row;
        logic signed [DATA_W-1:0] result_value;
        logic                     saturated;
        logic                     last;
    } rsp_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] diag;
        logic signed [DATA_W-1:0] upper;
        logic signed [DATA_W-1:0] lower;
    } coef_t;

endpackage

### sv/tridiagonal_matrix_vector_multiply_core.sv
// Tridiagonal matrix times streamed vector, signed Q16.16.
// Depends on tmvm_pkg.
//
// Usage:
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes the row count n; 0 acts as 1,
//   values above 1024 act as 1024. Each write restarts the vector. cfg_ready is
//   always high. Write it only while no request is in flight.
//   req channel carries load requests (mode 0: one row's three coefficients) and
//   vector requests (mode 1: x[0], x[1], ... in order). Vector element k >= 1
//   produces row k-1; element n-1 also produces row n-1 with last set.
//   rsp channel returns out_row, result_value, saturated and last.
// Timing:
//   One request per cycle while req_ready is high. Each vector request passes the
//   coefficient memory read, multiply and sum registers and then the result buffer;
//   a second result from the same request enters the buffer with the first one.
//   Results queue in an 8-entry buffer; req_ready drops once the buffer plus the
//   results still in the pipeline could exceed it, so a stalled receiver only
//   holds back requests. Reset empties the pipeline and the buffer, sets n to 1
//   and clears the vector position; coefficient memory is not cleared.
module tridiagonal_matrix_vector_multiply_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  tmvm_pkg::req_t             req,
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output tmvm_pkg::rsp_t             rsp,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [tmvm_pkg::LEN_W-1:0] cfg_data
);
    import tmvm_pkg::*;

    coef_t coef_mem [MAX_ROWS];

    logic [ADDR_W-1:0]         n_m1_reg, n_m1_next;
    logic [ADDR_W-1:0]         pos_reg, pos_next;
    logic signed [DATA_W-1:0]  prev_reg, prev_next;
    logic signed [DATA_W-1:0]  prev2_reg, prev2_next;
    logic [LEN_W-1:0]          len_clamped;

    logic                      req_fire, load_fire, vec_fire, load_ok;
    logic                      has_a, is_last, use_low_a;
    logic [ADDR_W-1:0]         addr_a, wr_addr;

    logic                      s1_valid_reg, s1_has_a_reg, s1_has_b_reg, s1_use_low_a_reg;
    logic [ADDR_W-1:0]         s1_row_reg;
    logic signed [DATA_W-1:0]  s1_x_reg, s1_xp_reg, s1_xpp_reg;
    coef_t                     rd_a_reg, rd_b_reg;
    logic signed [DATA_W-1:0]  low_a, low_b;

    logic                      s2_valid_reg, s2_has_a_reg, s2_has_b_reg;
    logic [ADDR_W-1:0]         s2_row_reg;
    logic signed [PROD_W-1:0]  p_a0_reg, p_a1_reg, p_a2_reg, p_b0_reg, p_b1_reg;

    logic                      s3_valid_reg, s3_has_a_reg, s3_has_b_reg;
    logic [ADDR_W-1:0]         s3_row_reg;
    logic signed [SUM_W-1:0]   sum_a_reg, sum_b_reg;
    rsp_t                      rsp_a, rsp_b;
    logic                      push_a, push_b;

    rsp_t                      fifo_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]     wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next, wr_ptr_b;
    logic [FIFO_CNT_W-1:0]     cnt_reg, cnt_next, used_reg, used_next, req_res, n_push;
    logic                      rsp_fire;

    function automatic rsp_t make_rsp(logic signed [SUM_W-1:0] s,
                                      logic [ADDR_W-1:0] row, logic fin);
        logic [SUM_W-FRAC_W-1:0]        t;
        logic [SUM_W-FRAC_W-DATA_W:0]   top;
        rsp_t                           r;
        t   = s[SUM_W-1:FRAC_W];
        top = t[SUM_W-FRAC_W-1:DATA_W-1];
        r.out_row = ROW_W'(row);
        r.last    = fin;
        if (top != '0 && top != '1)
        begin
            r.saturated    = 1'b1;
            r.result_value = t[SUM_W-FRAC_W-1] ? SAT_MIN : SAT_MAX;
        end
        else
        begin
            r.saturated    = 1'b0;
            r.result_value = t[DATA_W-1:0];
        end
        return r;
    endfunction

    assign cfg_ready = 1'b1;
    assign req_ready = used_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2);
    assign req_fire  = req_valid && req_ready;
    assign load_fire = req_fire && req.mode == MODE_LOAD;
    assign vec_fire  = req_fire && req.mode == MODE_VECTOR;
    assign load_ok   = int'(req.row_index) < MAX_ROWS;
    assign wr_addr   = ADDR_W'(req.row_index);

    assign has_a     = pos_reg != '0;
    assign is_last   = pos_reg == n_m1_reg;
    assign use_low_a = pos_reg > ADDR_W'(1);
    assign addr_a    = pos_reg - ADDR_W'(1);

    always_comb
    begin
        if (cfg_data == '0)
            len_clamped = LEN_W'(1);
        else if (cfg_data > LEN_W'(MAX_ROWS))
            len_clamped = LEN_W'(MAX_ROWS);
        else
            len_clamped = cfg_data;
    end

    always_comb
    begin
        n_m1_next  = n_m1_reg;
        pos_next   = pos_reg;
        prev_next  = prev_reg;
        prev2_next = prev2_reg;
        if (cfg_valid)
        begin
            n_m1_next = ADDR_W'(len_clamped - LEN_W'(1));
            pos_next  = '0;
        end
        else if (vec_fire)
        begin
            if (is_last)
            begin
                pos_next   = '0;
                prev_next  = '0;
                prev2_next = '0;
            end
            else
            begin
                pos_next   = pos_reg + ADDR_W'(1);
                prev2_next = prev_reg;
                prev_next  = req.vector_value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_m1_reg  <= '0;
            pos_reg   <= '0;
            prev_reg  <= '0;
            prev2_reg <= '0;
        end
        else
        begin
            n_m1_reg  <= n_m1_next;
            pos_reg   <= pos_next;
            prev_reg  <= prev_next;
            prev2_reg <= prev2_next;
        end
    end

    // Coefficient memory: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (load_fire && load_ok)
            coef_mem[wr_addr] <= '{diag: req.diag_coeff, upper: req.upper_coeff,
                                   lower: req.lower_coeff};
        if (vec_fire)
        begin
            rd_a_reg <= coef_mem[addr_a];
            rd_b_reg <= coef_mem[pos_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= vec_fire;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (vec_fire)
        begin
            s1_has_a_reg     <= has_a;
            s1_has_b_reg     <= is_last;
            s1_use_low_a_reg <= use_low_a;
            s1_row_reg       <= pos_reg;
            s1_x_reg         <= req.vector_value;
            s1_xp_reg        <= prev_reg;
            s1_xpp_reg       <= prev2_reg;
        end
    end

    // Drop the subdiagonal term of row 0.
    assign low_a = s1_use_low_a_reg ? rd_a_reg.lower : '0;
    assign low_b = s1_has_a_reg     ? rd_b_reg.lower : '0;

    always_ff @(posedge clk)
    begin
        s2_has_a_reg <= s1_has_a_reg;
        s2_has_b_reg <= s1_has_b_reg;
        s2_row_reg   <= s1_row_reg;
        p_a0_reg     <= low_a * s1_xpp_reg;
        p_a1_reg     <= rd_a_reg.diag * s1_xp_reg;
        p_a2_reg     <= rd_a_reg.upper * s1_x_reg;
        p_b0_reg     <= low_b * s1_xp_reg;
        p_b1_reg     <= rd_b_reg.diag * s1_x_reg;
    end

    always_ff @(posedge clk)
    begin
        s3_has_a_reg <= s2_has_a_reg;
        s3_has_b_reg <= s2_has_b_reg;
        s3_row_reg   <= s2_row_reg;
        sum_a_reg    <= SUM_W'(p_a0_reg) + SUM_W'(p_a1_reg) + SUM_W'(p_a2_reg);
        sum_b_reg    <= SUM_W'(p_b0_reg) + SUM_W'(p_b1_reg);
    end

    assign rsp_a  = make_rsp(sum_a_reg, s3_row_reg - ADDR_W'(1), 1'b0);
    assign rsp_b  = make_rsp(sum_b_reg, s3_row_reg, 1'b1);
    assign push_a = s3_valid_reg && s3_has_a_reg;
    assign push_b = s3_valid_reg && s3_has_b_reg;

    // Result buffer: up to two pushes, one pop per cycle.
    assign rsp_valid = cnt_reg != '0;
    assign rsp       = fifo_mem[rd_ptr_reg];
    assign rsp_fire  = rsp_valid && rsp_ready;
    assign wr_ptr_b  = wr_ptr_reg + FIFO_PTR_W'(push_a);
    assign n_push    = FIFO_CNT_W'(push_a) + FIFO_CNT_W'(push_b);
    assign req_res   = vec_fire ? FIFO_CNT_W'(has_a) + FIFO_CNT_W'(is_last) : '0;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(n_push);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(rsp_fire);
        cnt_next    = cnt_reg + n_push - FIFO_CNT_W'(rsp_fire);
        used_next   = used_reg + req_res - FIFO_CNT_W'(rsp_fire);
    end

    always_ff @(posedge clk)
    begin
        if (push_a)
            fifo_mem[wr_ptr_reg] <= rsp_a;
        if (push_b)
            fifo_mem[wr_ptr_b] <= rsp_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
            used_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
            used_reg   <= used_next;
        end
    end

endmodule

### sv/tmvm_checker.sv
// Port-level checker for the tridiagonal matrix-vector core, with its bind.
// Depends on tmvm_pkg and tridiagonal_matrix_vector_multiply_core_assert.svh.
`include "tridiagonal_matrix_vector_multiply_core_assert.svh"

module tmvm_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input tmvm_pkg::rsp_t rsp
);
    import tmvm_pkg::*;

    `TMVM_ASSERT(a_rsp_hold_valid, rsp_valid && !rsp_ready |=> rsp_valid, "rsp_valid dropped")
    `TMVM_ASSERT(a_rsp_hold_data, rsp_valid && !rsp_ready |=> $stable(rsp), "rsp changed")
    `TMVM_ASSERT(a_sat_clamped, rsp_valid && rsp.saturated |-> (rsp.result_value == SAT_MAX || rsp.result_value == SAT_MIN), "saturated result not clamped")
    `TMVM_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !rsp_valid, "rsp_valid during reset")

endmodule

bind tridiagonal_matrix_vector_multiply_core tmvm_checker u_tmvm_checker (.*);

### dv/tridiagonal_matrix_vector_multiply_core_checker.sv
// Result checker for the tridiagonal matrix-vector core: tracks the coefficient
// memories, vector position and row count, predicts every product row and compares.
// Depends on tmvm_pkg.
`timescale 1ns / 1ps

module tridiagonal_matrix_vector_multiply_core_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    input  logic                       req_ready,
    input  tmvm_pkg::req_t             req,
    input  logic                       rsp_valid,
    input  logic                       rsp_ready,
    input  tmvm_pkg::rsp_t             rsp,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [tmvm_pkg::LEN_W-1:0] cfg_data,
    output int                         fail_count,
    output int                         rows_pending
);
    import tmvm_pkg::*;

    localparam logic signed [SUM_W-1:0] SUM_MAX = SAT_MAX;
    localparam logic signed [SUM_W-1:0] SUM_MIN = SAT_MIN;

    logic signed [DATA_W-1:0] diag_mem  [MAX_ROWS];
    logic signed [DATA_W-1:0] upper_mem [MAX_ROWS];
    logic signed [DATA_W-1:0] lower_mem [MAX_ROWS];
    logic signed [DATA_W-1:0] x_prev;
    logic signed [DATA_W-1:0] x_prev2;
    logic [LEN_W-1:0]         next_pos;
    logic [LEN_W-1:0]         row_count;
    rsp_t                     expected_rows [$];

    function automatic rsp_t q16_row(input int row, input logic signed [PROD_W-1:0] p0,
                                     input logic signed [PROD_W-1:0] p1,
                                     input logic signed [PROD_W-1:0] p2, input logic is_last);
        logic signed [SUM_W-1:0] acc;
        rsp_t                    row_out;
        acc = p0 + p1 + p2;
        acc = acc >>> FRAC_W;
        row_out.out_row = ROW_W'(row);
        row_out.last    = is_last;
        if (acc > SUM_MAX)
        begin
            row_out.result_value = SAT_MAX;
            row_out.saturated    = 1'b1;
        end
        else if (acc < SUM_MIN)
        begin
            row_out.result_value = SAT_MIN;
            row_out.saturated    = 1'b1;
        end
        else
        begin
            row_out.result_value = acc[DATA_W-1:0];
            row_out.saturated    = 1'b0;
        end
        return row_out;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : predict_and_compare
        int                       n;
        int                       k;
        int                       r;
        logic signed [DATA_W-1:0] x;
        logic signed [PROD_W-1:0] p_lower;
        logic signed [PROD_W-1:0] p_diag;
        logic signed [PROD_W-1:0] p_upper;
        rsp_t                     want;
        rsp_t                     got;
        if (!rst_n)
        begin
            x_prev     = '0;
            x_prev2    = '0;
            next_pos   = '0;
            row_count  = LEN_W'(1);
            fail_count = 0;
            expected_rows.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                row_count = cfg_data;
                next_pos  = '0;
            end
            if (req_valid && req_ready)
            begin
                if (req.mode == MODE_LOAD)
                begin
                    diag_mem[req.row_index]  = req.diag_coeff;
                    upper_mem[req.row_index] = req.upper_coeff;
                    lower_mem[req.row_index] = req.lower_coeff;
                end
                else
                begin
                    n = (row_count == 0) ? 1 : ((row_count > MAX_ROWS) ? MAX_ROWS : int'(row_count));
                    k = int'(next_pos);
                    if (k >= n)
                        k = n - 1;
                    x = req.vector_value;
                    if (k >= 1)
                    begin
                        r = k - 1;
                        p_lower = '0;
                        if (r >= 1)
                            p_lower = lower_mem[r] * x_prev2;
                        p_diag  = diag_mem[r] * x_prev;
                        p_upper = upper_mem[r] * x;
                        expected_rows.push_back(q16_row(r, p_lower, p_diag, p_upper, 1'b0));
                    end
                    if (k == n - 1)
                    begin
                        p_lower = '0;
                        if (k >= 1)
                            p_lower = lower_mem[k] * x_prev;
                        p_diag = diag_mem[k] * x;
                        expected_rows.push_back(q16_row(k, p_lower, p_diag, '0, 1'b1));
                        next_pos = '0;
                        x_prev   = '0;
                        x_prev2  = '0;
                    end
                    else
                    begin
                        next_pos = LEN_W'(k + 1);
                        x_prev2  = x_prev;
                        x_prev   = x;
                    end
                end
            end
            if (rsp_valid && rsp_ready)
            begin
                got = rsp;
                if (expected_rows.size() == 0)
                begin
                    $error("result for row %0d arrived with none expected", got.out_row);
                    fail_count++;
                end
                else
                begin
                    want = expected_rows.pop_front();
                    if (got.out_row !== want.out_row)
                    begin
                        $error("out_row: expected %0d, got %0d", want.out_row, got.out_row);
                        fail_count++;
                    end
                    if (got.result_value !== want.result_value)
                    begin
                        $error("result_value: expected %h, got %h", want.result_value,
                               got.result_value);
                        fail_count++;
                    end
                    if (got.saturated !== want.saturated)
                    begin
                        $error("saturated: expected %b, got %b", want.saturated, got.saturated);
                        fail_count++;
                    end
                    if (got.last !== want.last)
                    begin
                        $error("last: expected %b, got %b", want.last, got.last);
                        fail_count++;
                    end
                end
            end
        end
        rows_pending = expected_rows.size();
    end

endmodule

### dv/tridiagonal_matrix_vector_multiply_core_tb.sv
// Top of the tridiagonal matrix-vector core testbench: clock, reset, request and
// length stimulus, result stall pattern, watchdog and verdict.
// Depends on tmvm_pkg, the core and tridiagonal_matrix_vector_multiply_core_checker.
`timescale 1ns / 1ps

module tridiagonal_matrix_vector_multiply_core_tb;

    import tmvm_pkg::*;

    localparam int ITEM_TARGET  = 1200;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 8;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             req_valid;
    logic             req_ready;
    req_t             req;
    logic             rsp_valid;
    logic             rsp_ready;
    rsp_t             rsp;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [LEN_W-1:0] cfg_data;

    int   fail_count;
    int   rows_pending;
    logic req_taken;
    logic cfg_taken;
    int   idle_cycles = 0;
    int   burst_left = 0;
    int   items_sent = 0;
    int   stall_left = 0;
    int   rx_mode = 0;
    int   rx_cycle = 0;
    bit   row_loaded [MAX_ROWS];

    always #5 clk = ~clk;

    tridiagonal_matrix_vector_multiply_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    tridiagonal_matrix_vector_multiply_core_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .req          (req),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .rsp          (rsp),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .rows_pending (rows_pending)
    );

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_taken   <= 1'b0;
            cfg_taken   <= 1'b0;
            idle_cycles = 0;
        end
        else
        begin
            req_taken <= req_valid && req_ready;
            cfg_taken <= cfg_valid && cfg_ready;
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // switch between no stalls, short stalls and long stalls
    always @(negedge clk)
    begin
        rx_cycle++;
        if (rx_cycle % 300 == 0)
            rx_mode = $urandom_range(0, 2);
        if (stall_left > 0)
            stall_left--;
        else if (rx_mode == 1 && $urandom_range(0, 9) < 3)
            stall_left = $urandom_range(1, 3);
        else if (rx_mode == 2 && $urandom_range(0, 19) == 0)
            stall_left = $urandom_range(5, 30);
        rsp_ready <= (stall_left == 0);
    end

    function automatic logic [DATA_W-1:0] rand_q16();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            case ($urandom_range(0, 5))
                0:       return SAT_MIN;
                1:       return SAT_MAX;
                2:       return 32'h0000_0000;
                3:       return 32'hFFFF_FFFF;
                4:       return 32'h0001_0000;
                default: return 32'hFFFF_0000;
            endcase
        end
        else if (pick <= 4)
            return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
        else if (pick <= 6)
            return $urandom_range(0, 32'h03FF_FFFF) - 32'h0200_0000;
        return $urandom();
    endfunction

    task automatic send_request(input req_t item);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 16);
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        req       <= item;
        req_valid <= 1'b1;
        do @(negedge clk); while (!req_taken);
        burst_left--;
        items_sent++;
    endtask

    task automatic load_row(input int row, input logic [DATA_W-1:0] diag,
                            input logic [DATA_W-1:0] upper, input logic [DATA_W-1:0] lower);
        req_t item;
        item.mode         = MODE_LOAD;
        item.row_index    = ROW_W'(row);
        item.diag_coeff   = diag;
        item.upper_coeff  = upper;
        item.lower_coeff  = lower;
        item.vector_value = $urandom();
        row_loaded[row]   = 1'b1;
        send_request(item);
    endtask

    task automatic push_element(input logic [DATA_W-1:0] value);
        req_t item;
        item.mode         = MODE_VECTOR;
        item.row_index    = ROW_W'($urandom());
        item.diag_coeff   = $urandom();
        item.upper_coeff  = $urandom();
        item.lower_coeff  = $urandom();
        item.vector_value = value;
        send_request(item);
    endtask

    // hold requests until every predicted row is back, then let the pipeline settle
    task automatic drain_results();
        req_valid <= 1'b0;
        @(negedge clk);
        while (rows_pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_length(input logic [LEN_W-1:0] length);
        drain_results();
        cfg_data  <= length;
        cfg_valid <= 1'b1;
        do @(negedge clk); while (!cfg_taken);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [LEN_W-1:0] length, input int vec_count,
                             input int noise_pct);
        int rows;
        int need;
        int sent;
        write_length(length);
        rows = (length == 0) ? 1 : ((length > MAX_ROWS) ? MAX_ROWS : int'(length));
        need = (vec_count < rows) ? vec_count : rows;
        for (int r = 0; r < need; r++)
        begin
            if (!row_loaded[r])
                load_row(r, rand_q16(), rand_q16(), rand_q16());
        end
        sent = 0;
        while (sent < vec_count)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                load_row(($urandom_range(0, 1) == 0) ? $urandom_range(0, rows - 1)
                                                     : $urandom_range(0, MAX_ROWS - 1),
                         rand_q16(), rand_q16(), rand_q16());
            else
            begin
                push_element(rand_q16());
                sent++;
            end
            if ($urandom_range(0, 49) == 0)
                drain_results();
        end
    endtask

    initial
    begin
        int rows;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        rsp_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // single row at the reset length: saturation both ways, zero, floor of negatives
        load_row(0, SAT_MIN, SAT_MAX, SAT_MIN);
        push_element(SAT_MIN);
        push_element(SAT_MAX);
        push_element(32'h0000_0000);
        load_row(0, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000);
        push_element(32'hFFFF_FFFF);
        load_row(0, 32'h0001_0000, SAT_MAX, 32'h0000_0000);
        push_element(SAT_MAX);

        // length zero acts as one
        write_length(LEN_W'(0));
        push_element(32'h0001_8000);

        // three rows with extreme neighbors
        write_length(LEN_W'(3));
        load_row(1, SAT_MAX, SAT_MIN, SAT_MAX);
        load_row(2, 32'hFFFF_0000, SAT_MIN, 32'h0001_0000);
        push_element(SAT_MAX);
        push_element(SAT_MIN);
        push_element(32'h0001_0000);

        // abandon a partial vector with a length write
        write_length(LEN_W'(2));
        push_element(32'h0002_0000);
        write_length(LEN_W'(3));
        push_element(32'hFFFE_0000);
        push_element(32'h0000_8000);
        push_element(SAT_MIN);

        // full size and a length clamped from the top: partial vectors
        run_phase(LEN_W'(MAX_ROWS), 3, 0);
        run_phase({LEN_W{1'b1}}, 20, 5);

        while (items_sent < ITEM_TARGET)
        begin
            case ($urandom_range(0, 19))
                0:       rows = 0;
                1:       rows = $urandom_range(MAX_ROWS, (1 << LEN_W) - 1);
                2, 3:    rows = $urandom_range(9, 64);
                default: rows = $urandom_range(1, 8);
            endcase
            if (rows > 64)
                run_phase(LEN_W'(rows), $urandom_range(1, 20), 10);
            else if (rows == 0)
                run_phase(LEN_W'(0), $urandom_range(1, 6), 10);
            else
                run_phase(LEN_W'(rows), $urandom_range(1, 3 * rows + 2), 10);
        end

        drain_results();
        if (fail_count == 0 && rows_pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
